// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module bcc_check.
// Each macro takes a label, clock, reset, antecedent and consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define BCC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcc check failed");

// Next-cycle implication, switched off while reset is high.
`define BCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcc check failed");

`endif

// ===== src/bcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam logic [5:0]  SEC_MAX     = 6'd59;
  localparam logic [5:0]  MIN_MAX     = 6'd59;
  localparam logic [4:0]  HOUR_MAX    = 5'd23;
  localparam logic [4:0]  HOUR_NOON   = 5'd12;
  localparam logic [3:0]  MONTH_MAX   = 4'd12;
  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [2:0]  WEEKDAY_MAX = 3'd6;
  localparam logic [6:0]  YLO_MAX     = 7'd99;

  // floor(y / 100) = (y * 5243) >> 19 for every y below 43699.
  localparam logic [26:0] DIV100_MUL   = 27'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam logic [13:0] HUNDRED      = 14'd100;

  // Reset values of the time and date.
  localparam logic [5:0]  RST_SEC     = 6'd58;
  localparam logic [5:0]  RST_MIN     = 6'd59;
  localparam logic [4:0]  RST_HOUR    = 5'd12;
  localparam logic [4:0]  RST_DAY     = 5'd8;
  localparam logic [3:0]  RST_MONTH   = 4'd1;
  localparam logic [13:0] RST_YEAR    = 14'd2018;
  localparam logic [2:0]  RST_WEEKDAY = 3'd1;
  localparam logic [6:0]  RST_YLO     = 7'd18;
  localparam logic [1:0]  RST_YHI4    = 2'd0;

  typedef struct packed {
    logic        command;
    logic [5:0]  load_second;
    logic [5:0]  load_minute;
    logic [4:0]  load_hour;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [13:0] load_year;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
    logic        pm;
    logic [3:0]  hour_twelve;
  } out_item_t;

  // An accepted item together with its year already split at the hundreds.
  typedef struct packed {
    in_item_t    item;
    logic [13:0] year_sat;
    logic [6:0]  year_lo;
    logic [1:0]  year_hi4;
  } stage_t;

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    begin
      if (m == 4'd2) begin
        len = leap ? 5'd29 : 5'd28;
      end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
        len = 5'd30;
      end else begin
        len = 5'd31;
      end
      return len;
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/bcd_clock_calendar.sv =====
// Time-of-day and Gregorian calendar counter.
// Input channel (item_valid, item_ready, item): each transfer carries a command.
// A tick command adds one second and ripples the carry through minutes, hours,
// day, month and year; midnight also steps the weekday counter modulo 7.
// A load sets time and date, saturating high values; day or month 0 becomes 1.
// Output channel (result_valid, result_ready, result): one transfer per item,
// holding the full time and date after that item plus a 12-hour view.
// An accepted item waits in the input register (where the year is already split
// at the hundreds for the leap-year test), and the counter update then writes
// the result register.
// Throughput: one item per cycle while the receiver takes each result.
// When the receiver stalls, the result register holds its transfer and the
// input register still takes one more item; only then does item_ready drop.
// Reset (rst, synchronous, active high) empties both registers and sets the
// clock to 12:59:58 on 8 January 2018, weekday 1.
`timescale 1ns / 1ps
`default_nettype none

module bcd_clock_calendar import bcc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_ready,
  input  wire in_item_t item,
  output logic          result_valid,
  input  wire logic     result_ready,
  output out_item_t     result
);

  // Handshake between the input register and the counter update.
  logic   stage_valid;
  logic   advance;
  stage_t stage;

  bcc_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  // The counters themselves live here and move only when a result is
  // written into the output register.
  bcc_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (stage_valid),
    .stage        (stage),
    .advance      (advance),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== src/bcc_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcc_in_stage import bcc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_ready,
  input  wire in_item_t item,
  input  wire logic     advance,
  output logic          stage_valid,
  output stage_t        stage
);

  logic [13:0] year_sat;
  logic [26:0] prod;
  logic [6:0]  hundreds;
  logic [13:0] hundreds_x100;
  stage_t      stage_next;

  // Split the year into y / 100 and y % 100 so that leap years need no divider.
  always_comb begin
    year_sat      = (item.load_year > YEAR_MAX) ? YEAR_MAX : item.load_year;
    prod          = 27'(year_sat) * DIV100_MUL;
    hundreds      = prod[DIV100_SHIFT +: 7];
    hundreds_x100 = 14'(hundreds) * HUNDRED;
    stage_next.item     = item;
    stage_next.year_sat = year_sat;
    stage_next.year_lo  = year_sat[6:0] - hundreds_x100[6:0];
    stage_next.year_hi4 = hundreds[1:0];
  end

  assign item_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage <= stage_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/bcc_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcc_engine import bcc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   stage_valid,
  input  wire stage_t stage,
  output logic        advance,
  output logic        result_valid,
  input  wire logic   result_ready,
  output out_item_t   result
);

  logic [5:0]  sec, sec_next;
  logic [5:0]  mins, mins_next;
  logic [4:0]  hr, hr_next;
  logic [4:0]  dy, dy_next;
  logic [3:0]  mon, mon_next;
  logic [13:0] yr, yr_next;
  logic [2:0]  wd, wd_next;
  logic [6:0]  ylo, ylo_next;
  logic [1:0]  yhi4, yhi4_next;
  logic        leap;
  out_item_t   result_next;

  assign advance = stage_valid && (!result_valid || result_ready);

  // Leap when y % 4 == 0 and y % 100 != 0, or when y % 400 == 0.
  assign leap = ((ylo[1:0] == 2'd0) && (ylo != 7'd0)) ||
                ((ylo == 7'd0) && (yhi4 == 2'd0));

  always_comb begin
    sec_next  = sec;
    mins_next = mins;
    hr_next   = hr;
    dy_next   = dy;
    mon_next  = mon;
    yr_next   = yr;
    wd_next   = wd;
    ylo_next  = ylo;
    yhi4_next = yhi4;
    if (stage.item.command == CMD_LOAD) begin
      sec_next  = (stage.item.load_second > SEC_MAX) ? SEC_MAX : stage.item.load_second;
      mins_next = (stage.item.load_minute > MIN_MAX) ? MIN_MAX : stage.item.load_minute;
      hr_next   = (stage.item.load_hour > HOUR_MAX) ? HOUR_MAX : stage.item.load_hour;
      dy_next   = (stage.item.load_day == 5'd0) ? 5'd1 : stage.item.load_day;
      if (stage.item.load_month == 4'd0) begin
        mon_next = 4'd1;
      end else if (stage.item.load_month > MONTH_MAX) begin
        mon_next = MONTH_MAX;
      end else begin
        mon_next = stage.item.load_month;
      end
      yr_next   = stage.year_sat;
      ylo_next  = stage.year_lo;
      yhi4_next = stage.year_hi4;
    end else if (sec < SEC_MAX) begin
      sec_next = sec + 6'd1;
    end else begin
      sec_next = 6'd0;
      if (mins < MIN_MAX) begin
        mins_next = mins + 6'd1;
      end else begin
        mins_next = 6'd0;
        if (hr < HOUR_MAX) begin
          hr_next = hr + 5'd1;
        end else begin
          hr_next = 5'd0;
          wd_next = (wd >= WEEKDAY_MAX) ? 3'd0 : wd + 3'd1;
          if (dy >= month_length(mon, leap)) begin
            dy_next = 5'd1;
            if (mon >= MONTH_MAX) begin
              mon_next = 4'd1;
              if (yr >= YEAR_MAX) begin
                yr_next   = 14'd0;
                ylo_next  = 7'd0;
                yhi4_next = 2'd0;
              end else begin
                yr_next = yr + 14'd1;
                if (ylo >= YLO_MAX) begin
                  ylo_next  = 7'd0;
                  yhi4_next = yhi4 + 2'd1;
                end else begin
                  ylo_next = ylo + 7'd1;
                end
              end
            end else begin
              mon_next = mon + 4'd1;
            end
          end else begin
            dy_next = dy + 5'd1;
          end
        end
      end
    end
  end

  always_comb begin
    result_next.second  = sec_next;
    result_next.minute  = mins_next;
    result_next.hour    = hr_next;
    result_next.day     = dy_next;
    result_next.month   = mon_next;
    result_next.year    = yr_next;
    result_next.weekday = wd_next;
    result_next.pm      = (hr_next >= HOUR_NOON);
    if (hr_next == 5'd0) begin
      result_next.hour_twelve = 4'd12;
    end else if (hr_next > HOUR_NOON) begin
      result_next.hour_twelve = 4'(hr_next - HOUR_NOON);
    end else begin
      result_next.hour_twelve = hr_next[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sec          <= RST_SEC;
      mins         <= RST_MIN;
      hr           <= RST_HOUR;
      dy           <= RST_DAY;
      mon          <= RST_MONTH;
      yr           <= RST_YEAR;
      wd           <= RST_WEEKDAY;
      ylo          <= RST_YLO;
      yhi4         <= RST_YHI4;
      result_valid <= 1'b0;
    end else if (advance) begin
      sec          <= sec_next;
      mins         <= mins_next;
      hr           <= hr_next;
      dy           <= dy_next;
      mon          <= mon_next;
      yr           <= yr_next;
      wd           <= wd_next;
      ylo          <= ylo_next;
      yhi4         <= yhi4_next;
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/bcc_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bcc_check import bcc_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      result_valid,
  input wire logic      result_ready,
  input wire out_item_t result
);

  logic time_ok;
  logic twelve_ok;

  assign time_ok = (result.second <= SEC_MAX) && (result.minute <= MIN_MAX) &&
                   (result.hour <= HOUR_MAX);

  assign twelve_ok = (result.hour_twelve >= 4'd1) && (result.hour_twelve <= 4'd12) &&
                     ((result.hour_twelve == result.hour[3:0]) ||
                      (result.hour_twelve == 4'(result.hour - HOUR_NOON)) ||
                      ((result.hour == 5'd0) && (result.hour_twelve == 4'd12)));

  `BCC_ASSERT_NEXT(a_hold_valid, clk, rst, result_valid && !result_ready, result_valid)
  `BCC_ASSERT_NEXT(a_hold_data, clk, rst, result_valid && !result_ready, $stable(result))
  `BCC_ASSERT_NOW(a_time_range, clk, rst, result_valid, time_ok)
  `BCC_ASSERT_NOW(a_pm_flag, clk, rst, result_valid, result.pm == (result.hour >= HOUR_NOON))
  `BCC_ASSERT_NOW(a_twelve_hour, clk, rst, result_valid, twelve_ok)

endmodule

bind bcd_clock_calendar bcc_check u_bcc_check (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire
